/* hdl/drfp_pkg.sv */
// shared types, constants and helpers for the readout frame parser
`timescale 1ns / 1ps
package drfp_pkg;

	localparam int HEADER_BYTES = 19;
	localparam int FRAME_BYTES  = 20;
	localparam int OFFSET_W     = 5;
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0]  MARKER_RESET = 8'hA0;
	localparam logic [15:0] FRAMES_MAX   = 16'hFFFF;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HEADER,
		PH_FRAMES,
		PH_CRC
	} phase_t;

	typedef enum logic {
		KIND_FRAME,
		KIND_END
	} kind_t;

	// one result job handed from the front to the back
	typedef struct packed {
		kind_t        kind;
		logic [7:0]   board_id;
		logic [23:0]  trigger_count;
		logic [47:0]  abs_bytes;
		logic [23:0]  trigger_crossing;
		logic [7:0]   chip_id;
		logic [23:0]  gray_crossing;
		logic [63:0]  pad_level_zero;
		logic [63:0]  pad_level_one;
		logic [15:0]  frame_count;
	} job_t;

	typedef struct packed {
		logic push;
		job_t job;
	} push_t;

	typedef struct packed {
		logic not_empty;
		logic full;
	} qstat_t;

	function automatic logic [23:0] gray_to_bin24(input logic [23:0] g);
		logic [23:0] b;
		b = '0;
		for (int i = 0; i < 24; i++) begin
			b[i] = ^(g >> i);
		end
		return b;
	endfunction

endpackage

/* hdl/detector_readout_frame_parser.sv */
// top level of the readout frame parser
//
//  channel | signals                         | direction | moves
//  in      | in_valid, in_ready              | input     | one payload word per accept
//  out     | out_valid, out_ready            | output    | one frame or end word
//  cfg     | cfg_write_en, cfg_write_data    | input     | trailer marker, no read-back
//
// one input word per cycle while in_ready is high; a result is written to a queue entry
// at the edge that takes its last word, then loaded into the output register
// the two-entry queue takes the front's jobs while the output register waits
// in_ready drops while the queue is full, whatever the word
// reset empties the queue, returns to idle and sets the trailer marker to 0xa0
`timescale 1ns / 1ps
module detector_readout_frame_parser
	import drfp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         data_byte,
	input  logic               start_of_payload,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               result_kind,
	output logic [7:0]         board_id,
	output logic [23:0]        trigger_count,
	output logic [40:0]        absolute_crossing,
	output logic [23:0]        trigger_crossing,
	output logic [7:0]         chip_id,
	output logic [23:0]        frame_crossing,
	output logic signed [24:0] time_to_trigger,
	output logic [63:0]        pad_level_zero,
	output logic [63:0]        pad_level_one,
	output logic [15:0]        frame_count,
	input  logic               cfg_write_en,
	input  logic [7:0]         cfg_write_data
);

	logic [7:0] marker_q;
	push_t      push;
	job_t       head;
	qstat_t     stat;
	logic       pop;
	logic       accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_q <= MARKER_RESET;
		end else if (cfg_write_en) begin
			marker_q <= cfg_write_data;
		end
	end

	assign in_ready = !stat.full;
	assign accept   = in_valid && in_ready;

	drfp_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.accept           (accept),
		.data_byte        (data_byte),
		.start_of_payload (start_of_payload),
		.trailer_marker   (marker_q),
		.push             (push)
	);

	drfp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.stat   (stat)
	);

	drfp_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.head              (head),
		.stat              (stat),
		.pop               (pop),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.result_kind       (result_kind),
		.board_id          (board_id),
		.trigger_count     (trigger_count),
		.absolute_crossing (absolute_crossing),
		.trigger_crossing  (trigger_crossing),
		.chip_id           (chip_id),
		.frame_crossing    (frame_crossing),
		.time_to_trigger   (time_to_trigger),
		.pad_level_zero    (pad_level_zero),
		.pad_level_one     (pad_level_one),
		.frame_count       (frame_count)
	);

endmodule

/* hdl/drfp_front.sv */
// front end: byte classification, header capture and frame assembly
`timescale 1ns / 1ps
module drfp_front
	import drfp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [7:0]  data_byte,
	input  logic        start_of_payload,
	input  logic [7:0]  trailer_marker,
	output push_t       push
);

	localparam logic [OFFSET_W-1:0] OFF_BOARD     = OFFSET_W'(0);
	localparam logic [OFFSET_W-1:0] OFF_GTC_FIRST = OFFSET_W'(3);
	localparam logic [OFFSET_W-1:0] OFF_GTC_LAST  = OFFSET_W'(5);
	localparam logic [OFFSET_W-1:0] OFF_ABS_FIRST = OFFSET_W'(6);
	localparam logic [OFFSET_W-1:0] OFF_ABS_LAST  = OFFSET_W'(11);
	localparam logic [OFFSET_W-1:0] OFF_TRG_FIRST = OFFSET_W'(12);
	localparam logic [OFFSET_W-1:0] OFF_TRG_LAST  = OFFSET_W'(14);
	localparam logic [OFFSET_W-1:0] OFF_HDR_LAST  = OFFSET_W'(HEADER_BYTES - 1);
	localparam logic [OFFSET_W-1:0] OFF_GRAY_LAST = OFFSET_W'(3);
	localparam logic [OFFSET_W-1:0] OFF_PAD_FIRST = OFFSET_W'(4);
	localparam logic [OFFSET_W-1:0] OFF_FRM_LAST  = OFFSET_W'(FRAME_BYTES - 1);

	phase_t              phase_q, phase_d;
	logic [OFFSET_W-1:0] offset_q, offset_d;
	logic [15:0]         frames_q, frames_d;
	logic [7:0]          board_q, board_d;
	logic [23:0]         gtc_q, gtc_d;
	logic [47:0]         abs_q, abs_d;
	logic [23:0]         trig_q, trig_d;
	logic [7:0]          chip_q, chip_d;
	logic [23:0]         gray_q, gray_d;
	logic [63:0]         pad0_q, pad0_d;
	logic [63:0]         pad1_q, pad1_d;

	logic [OFFSET_W-1:0] pad_off;
	logic [3:0]          nib_sel;
	logic [3:0]          nib0;
	logic [3:0]          nib1;

	// pad nibble chosen by the data byte index, bits alternate level 0 / level 1
	always_comb begin
		pad_off = offset_q - OFF_PAD_FIRST;
		nib_sel = {~pad_off[3:2], pad_off[1:0]};
		for (int m = 0; m < 4; m++) begin
			nib0[m] = data_byte[7 - 2 * m];
			nib1[m] = data_byte[6 - 2 * m];
		end
	end

	always_comb begin
		phase_d  = phase_q;
		offset_d = offset_q;
		frames_d = frames_q;
		board_d  = board_q;
		gtc_d    = gtc_q;
		abs_d    = abs_q;
		trig_d   = trig_q;
		chip_d   = chip_q;
		gray_d   = gray_q;
		pad0_d   = pad0_q;
		pad1_d   = pad1_q;
		push     = '0;
		if (accept) begin
			if (start_of_payload) begin
				phase_d  = PH_HEADER;
				offset_d = '0;
				frames_d = '0;
				board_d  = '0;
				gtc_d    = '0;
				abs_d    = '0;
				trig_d   = '0;
			end else begin
				case (phase_q)
					PH_HEADER: begin
						if (offset_q == OFF_BOARD) begin
							board_d = data_byte;
						end else if (offset_q >= OFF_GTC_FIRST && offset_q <= OFF_GTC_LAST) begin
							gtc_d = {gtc_q[15:0], data_byte};
						end else if (offset_q >= OFF_ABS_FIRST && offset_q <= OFF_ABS_LAST) begin
							abs_d = {abs_q[39:0], data_byte};
						end else if (offset_q >= OFF_TRG_FIRST && offset_q <= OFF_TRG_LAST) begin
							trig_d = {trig_q[15:0], data_byte};
						end
						if (offset_q == OFF_HDR_LAST) begin
							phase_d  = PH_FRAMES;
							offset_d = '0;
						end else begin
							offset_d = offset_q + 1'b1;
						end
					end
					PH_FRAMES: begin
						if (offset_q == '0 && data_byte == trailer_marker) begin
							phase_d  = PH_CRC;
							offset_d = '0;
						end else begin
							if (offset_q == '0) begin
								chip_d = data_byte;
								pad0_d = '0;
								pad1_d = '0;
							end else if (offset_q <= OFF_GRAY_LAST) begin
								gray_d = {gray_q[15:0], data_byte};
							end else begin
								for (int n = 0; n < 16; n++) begin
									if (nib_sel == 4'(n)) begin
										pad0_d[n*4 +: 4] = pad0_q[n*4 +: 4] | nib0;
										pad1_d[n*4 +: 4] = pad1_q[n*4 +: 4] | nib1;
									end
								end
							end
							if (offset_q == OFF_FRM_LAST) begin
								offset_d = '0;
								if (frames_q != FRAMES_MAX) begin
									frames_d = frames_q + 1'b1;
								end
								push.push                  = 1'b1;
								push.job.kind              = KIND_FRAME;
								push.job.board_id          = board_q;
								push.job.trigger_count     = gtc_q;
								push.job.abs_bytes         = abs_q;
								push.job.trigger_crossing  = trig_q;
								push.job.chip_id           = chip_d;
								push.job.gray_crossing     = gray_d;
								push.job.pad_level_zero    = pad0_d;
								push.job.pad_level_one     = pad1_d;
							end else begin
								offset_d = offset_q + 1'b1;
							end
						end
					end
					PH_CRC: begin
						if (offset_q == '0) begin
							offset_d = OFFSET_W'(1);
						end else begin
							phase_d  = PH_IDLE;
							offset_d = '0;
							push.push                 = 1'b1;
							push.job.kind             = KIND_END;
							push.job.board_id         = board_q;
							push.job.trigger_count    = gtc_q;
							push.job.abs_bytes        = abs_q;
							push.job.trigger_crossing = trig_q;
							push.job.frame_count      = frames_q;
						end
					end
					default: begin
						phase_d = phase_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			offset_q <= '0;
			frames_q <= '0;
		end else begin
			phase_q  <= phase_d;
			offset_q <= offset_d;
			frames_q <= frames_d;
		end
	end

	// header and frame payload, always rewritten before use
	always_ff @(posedge clk) begin
		board_q <= board_d;
		gtc_q   <= gtc_d;
		abs_q   <= abs_d;
		trig_q  <= trig_d;
		chip_q  <= chip_d;
		gray_q  <= gray_d;
		pad0_q  <= pad0_d;
		pad1_q  <= pad1_d;
	end

endmodule

/* hdl/drfp_queue.sv */
// short job queue between the parser front and the result back end
`timescale 1ns / 1ps
module drfp_queue
	import drfp_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  push_t  push,
	input  logic   pop,
	output job_t   head,
	output qstat_t stat
);

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign stat.not_empty = (count_q != '0);
	assign stat.full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign do_push        = push.push && !stat.full;
	assign do_pop         = pop && stat.not_empty;
	assign head           = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.job;
		end
	end

endmodule

/* hdl/drfp_back.sv */
// back end: crossing decode, trigger distance and the output register
`timescale 1ns / 1ps
module drfp_back
	import drfp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  job_t               head,
	input  qstat_t             stat,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               result_kind,
	output logic [7:0]         board_id,
	output logic [23:0]        trigger_count,
	output logic [40:0]        absolute_crossing,
	output logic [23:0]        trigger_crossing,
	output logic [7:0]         chip_id,
	output logic [23:0]        frame_crossing,
	output logic signed [24:0] time_to_trigger,
	output logic [63:0]        pad_level_zero,
	output logic [63:0]        pad_level_one,
	output logic [15:0]        frame_count
);

	logic        valid_q;
	logic [23:0] fc;
	logic [24:0] ttt;
	logic [40:0] abs_sum;

	assign pop = stat.not_empty && (!valid_q || out_ready);

	always_comb begin
		fc  = gray_to_bin24(head.gray_crossing);
		ttt = {1'b0, head.trigger_crossing} - {1'b0, fc};
		// upper 16 bits sit at 2^24, overlapping the lower 32
		abs_sum = {1'b0, head.abs_bytes[47:32], 24'd0} + {9'd0, head.abs_bytes[31:0]};
		if (head.kind == KIND_END) begin
			fc  = '0;
			ttt = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			result_kind       <= (head.kind == KIND_END);
			board_id          <= head.board_id;
			trigger_count     <= head.trigger_count;
			absolute_crossing <= abs_sum;
			trigger_crossing  <= head.trigger_crossing;
			chip_id           <= head.chip_id;
			frame_crossing    <= fc;
			time_to_trigger   <= $signed(ttt);
			pad_level_zero    <= head.pad_level_zero;
			pad_level_one     <= head.pad_level_one;
			frame_count       <= head.frame_count;
		end
	end

	assign out_valid = valid_q;

endmodule

/* hdl/drfp_chk.sv */
// port-level checks on the readout frame parser
`timescale 1ns / 1ps
module drfp_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic               result_kind,
	input logic [23:0]        trigger_crossing,
	input logic [7:0]         chip_id,
	input logic [23:0]        frame_crossing,
	input logic signed [24:0] time_to_trigger,
	input logic [63:0]        pad_level_zero,
	input logic [63:0]        pad_level_one,
	input logic [15:0]        frame_count
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(frame_count) && $stable(chip_id))
		else $error("output word changed while stalled");

	a_frame_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !result_kind |-> frame_count == 16'd0)
		else $error("frame word carries a frame count");

	a_end_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind |-> chip_id == 8'd0 && frame_crossing == 24'd0 &&
			time_to_trigger == 25'sd0 && pad_level_zero == 64'd0 && pad_level_one == 64'd0)
		else $error("end word carries frame fields");

	a_ttt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !result_kind |->
			time_to_trigger == $signed({1'b0, trigger_crossing} - {1'b0, frame_crossing}))
		else $error("time to trigger mismatch");

endmodule

bind detector_readout_frame_parser drfp_chk u_drfp_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.result_kind      (result_kind),
	.trigger_crossing (trigger_crossing),
	.chip_id          (chip_id),
	.frame_crossing   (frame_crossing),
	.time_to_trigger  (time_to_trigger),
	.pad_level_zero   (pad_level_zero),
	.pad_level_one    (pad_level_one),
	.frame_count      (frame_count)
);
